// ----- hw/rtl/bdos_pkg.sv -----
// Package for the button debounce and one-hot select block.
// Holds field widths, register indexes and the result struct.
// No dependencies; every other file of the block uses it.
package bdos_pkg;

   // Fixed field widths of the item channels.
   localparam int RAW_W   = 16;
   localparam int TIME_W  = 32;
   localparam int ACTIVE_W = 5;
   localparam int LED_W   = 16;
   localparam int DTIME_W = 16;

   // Widest selection index the button count range can need (64 buttons).
   localparam int SEL_MAX_W = 7;

   // Number of LEDs that may be lit.
   localparam int LedTotal = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TIME   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_ENABLE = 2'd1;

   // Reset values of the registers.
   localparam logic [DTIME_W-1:0] DEBOUNCE_TIME_RESET = 16'd20;
   localparam logic DEBOUNCE_ENABLE_RESET = 1'b1;

   // One result item.
   typedef struct packed {
      logic [ACTIVE_W-1:0] active_button;
      logic [LED_W-1:0]    led_bits;
      logic [RAW_W-1:0]    pressed_bits;
      logic                selection_changed;
   } result_type;

endpackage

// ----- hw/rtl/bdos_if.sv -----
// Valid/ready channel interfaces for the scan items and the result items.
// Depends on bdos_pkg for the field widths.

interface bdos_req_if;
   logic                           valid;
   logic                           ready;
   logic [bdos_pkg::RAW_W-1:0]     raw_levels;
   logic [bdos_pkg::TIME_W-1:0]    now_ms;

   modport source (output valid, output raw_levels, output now_ms, input ready);
   modport sink (input valid, input raw_levels, input now_ms, output ready);
endinterface

interface bdos_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bdos_pkg::ACTIVE_W-1:0]  active_button;
   logic [bdos_pkg::LED_W-1:0]     led_bits;
   logic [bdos_pkg::RAW_W-1:0]     pressed_bits;
   logic                           selection_changed;

   modport source (output valid, output active_button, output led_bits,
                   output pressed_bits, output selection_changed, input ready);
   modport sink (input valid, input active_button, input led_bits,
                 input pressed_bits, input selection_changed, output ready);
endinterface

// ----- hw/rtl/bdos_lane.sv -----
// One debounce lane: raw level history, change timestamp and debounced level
// of a single button. Depends on bdos_pkg for widths.
module bdos_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           raw_pressed,
   input  logic [bdos_pkg::TIME_W-1:0]    now_ms,
   input  logic [bdos_pkg::DTIME_W-1:0]   debounce_time,
   input  logic                           debounce_enable,
   output logic                           pressed,
   output logic                           pressed_next
);

   logic                          raw_prev_ff;
   logic                          raw_prev_in;
   logic                          pressed_ff;
   logic                          pressed_in;
   logic [bdos_pkg::TIME_W-1:0]   stamp_ff;
   logic [bdos_pkg::TIME_W-1:0]   stamp_in;
   logic [bdos_pkg::TIME_W-1:0]   elapsed;

   // With debounce enabled, a change of the raw level restarts the stability window.
   always_comb begin
      stamp_in    = stamp_ff;
      raw_prev_in = raw_prev_ff;
      if (debounce_enable) begin
         raw_prev_in = raw_pressed;
         if (raw_pressed != raw_prev_ff) begin
            stamp_in = now_ms;
         end
      end
      elapsed = now_ms - stamp_in;
   end

   // The debounced level takes the raw level once it has been stable long enough, or at once with debounce off.
   always_comb begin
      pressed_in = pressed_ff;
      if (!debounce_enable) begin
         pressed_in = raw_pressed;
      end else if (elapsed >= bdos_pkg::TIME_W'(debounce_time)) begin
         pressed_in = raw_pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff <= 1'b0;
         pressed_ff  <= 1'b0;
         stamp_ff    <= '0;
      end else if (accept) begin
         raw_prev_ff <= raw_prev_in;
         pressed_ff  <= pressed_in;
         stamp_ff    <= stamp_in;
      end
   end

   assign pressed      = pressed_ff;
   assign pressed_next = pressed_in;

endmodule

// ----- hw/rtl/bdos_select.sv -----
// Merging stage: picks the selected button from the lanes' debounced levels
// and forms the result item. Depends on bdos_pkg.
module bdos_select #(
   parameter int BUTTON_COUNT = 16,
   parameter int SEL_W = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [BUTTON_COUNT-1:0]   pressed_old,
   input  logic [BUTTON_COUNT-1:0]   pressed_new,
   output bdos_pkg::result_type      result
);

   logic [SEL_W-1:0]                 sel_ff;
   logic [SEL_W-1:0]                 sel_in;
   logic [SEL_W-1:0]                 newest;
   logic [SEL_W-1:0]                 lowest;
   logic                             sel_held;
   logic [bdos_pkg::SEL_MAX_W:0]     sel_wide;
   logic [BUTTON_COUNT-1:0]          fresh;

   // Highest numbered new press, lowest pressed button, and whether the
   // current selection is still held down.
   always_comb begin
      fresh    = ~pressed_old & pressed_new;
      newest   = '0;
      lowest   = '0;
      sel_held = 1'b0;
      for (int k = 0; k < BUTTON_COUNT; k++) begin
         if (fresh[k]) begin
            newest = SEL_W'(k + 1);
         end
         if (sel_ff == SEL_W'(k + 1) && pressed_new[k]) begin
            sel_held = 1'b1;
         end
      end
      for (int k = BUTTON_COUNT - 1; k >= 0; k--) begin
         if (pressed_new[k]) begin
            lowest = SEL_W'(k + 1);
         end
      end
   end

   // A new press wins; a released selection falls back to the lowest pressed.
   always_comb begin
      if (newest != '0) begin
         sel_in = newest;
      end else if (sel_ff == '0 || sel_held) begin
         sel_in = sel_ff;
      end else begin
         sel_in = lowest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else if (accept) begin
         sel_ff <= sel_in;
      end
   end

   // Result fields, each limited to its own width.
   always_comb begin
      sel_wide = (bdos_pkg::SEL_MAX_W + 1)'(sel_in);
      result.active_button = sel_wide[bdos_pkg::ACTIVE_W-1:0];
      for (int k = 0; k < bdos_pkg::LED_W; k++) begin
         result.led_bits[k] = (k < bdos_pkg::LedTotal) &&
                              (sel_wide == (bdos_pkg::SEL_MAX_W + 1)'(k + 1));
      end
      for (int k = 0; k < bdos_pkg::RAW_W; k++) begin
         if (k < BUTTON_COUNT) begin
            result.pressed_bits[k] = pressed_new[k];
         end else begin
            result.pressed_bits[k] = 1'b0;
         end
      end
      result.selection_changed = (sel_in != sel_ff);
   end

endmodule

// ----- hw/rtl/button_debounce_one_hot_select.sv -----
// Button debounce with last-press-wins one-hot selection.
// Each result item is loaded into the output register when its scan item is accepted.
// Throughput: one item per cycle while the result side drains; the debounce lanes and
// the selection encoder are combinational, and the output register holds one waiting result.
// Reset clears all button history, timestamps and the selection, and sets the
// debounce registers to 20 ms, enabled.
module button_debounce_one_hot_select #(
   parameter int BUTTON_COUNT = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   bdos_req_if.sink                           req_chan,
   bdos_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [bdos_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdos_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SEL_W = $clog2(BUTTON_COUNT + 1);

   logic [bdos_pkg::DTIME_W-1:0]   debounce_time_ff;
   logic                           debounce_enable_ff;
   logic                           accept;
   logic [BUTTON_COUNT-1:0]        raw_pressed;
   logic [BUTTON_COUNT-1:0]        pressed_old;
   logic [BUTTON_COUNT-1:0]        pressed_new;
   bdos_pkg::result_type           result;
   bdos_pkg::result_type           rsp_data_ff;
   logic                           rsp_valid_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff   <= bdos_pkg::DEBOUNCE_TIME_RESET;
         debounce_enable_ff <= bdos_pkg::DEBOUNCE_ENABLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bdos_pkg::CSR_DEBOUNCE_TIME: begin
               debounce_time_ff <= csr_wdata[bdos_pkg::DTIME_W-1:0];
            end
            bdos_pkg::CSR_DEBOUNCE_ENABLE: begin
               debounce_enable_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // An item is taken whenever the output register is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   // One lane per button; buttons beyond the scan width read as released.
   for (genvar k = 0; k < BUTTON_COUNT; k++) begin : g_lane
      if (k < bdos_pkg::RAW_W) begin : g_raw
         assign raw_pressed[k] = ~req_chan.raw_levels[k];
      end else begin : g_none
         assign raw_pressed[k] = 1'b0;
      end

      bdos_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .accept          (accept),
         .raw_pressed     (raw_pressed[k]),
         .now_ms          (req_chan.now_ms),
         .debounce_time   (debounce_time_ff),
         .debounce_enable (debounce_enable_ff),
         .pressed         (pressed_old[k]),
         .pressed_next    (pressed_new[k])
      );
   end

   bdos_select #(
      .BUTTON_COUNT (BUTTON_COUNT),
      .SEL_W        (SEL_W)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pressed_old (pressed_old),
      .pressed_new (pressed_new),
      .result      (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.active_button     = rsp_data_ff.active_button;
   assign rsp_chan.led_bits          = rsp_data_ff.led_bits;
   assign rsp_chan.pressed_bits      = rsp_data_ff.pressed_bits;
   assign rsp_chan.selection_changed = rsp_data_ff.selection_changed;

endmodule

// ----- dv/bdos_result_checker.sv -----
`timescale 1ns / 100ps
// Checker for the button debounce and one-hot select block: predicts each result
// item from the accepted scan items and register writes, then compares in order.
// Depends on bdos_pkg and the bdos_req_if / bdos_rsp_if interfaces.
module bdos_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   bdos_req_if                               req_mon,
   bdos_rsp_if                               rsp_mon,
   input  logic                              csr_we,
   input  logic [bdos_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bdos_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                mismatches,
   output int                                outstanding
);
   import bdos_pkg::*;

   localparam int Buttons = 16;

   // Shadow copy of the registers.
   logic [DTIME_W-1:0] settle_ms;
   logic               settle_on;

   // Shadow copy of the button history and selection, as pressed masks.
   logic [RAW_W-1:0]   raw_seen;
   logic [RAW_W-1:0]   stable_down;
   logic [RAW_W-1:0]   stable_seen;
   logic [TIME_W-1:0]  edge_ms [Buttons];
   logic [ACTIVE_W-1:0] chosen;
   logic [ACTIVE_W-1:0] chosen_seen;

   result_type due_results[$];

   // Works out the result of one scan and advances the shadow state.
   task automatic predict_scan(input logic [RAW_W-1:0] levels,
                               input logic [TIME_W-1:0] now,
                               output result_type res);
      logic [RAW_W-1:0]  down;
      logic [TIME_W-1:0] held;
      down = ~levels;
      if (!settle_on) begin
         stable_down = down;
      end else begin
         for (int k = 0; k < Buttons; k++) begin
            if (down[k] != raw_seen[k]) edge_ms[k] = now;
            held = now - edge_ms[k];
            if (held >= {16'd0, settle_ms} && down[k] != stable_down[k])
               stable_down[k] = down[k];
         end
         raw_seen = down;
      end
      // A new press takes the selection; the highest numbered one wins.
      for (int k = 0; k < Buttons; k++) begin
         if (!stable_seen[k] && stable_down[k]) chosen = ACTIVE_W'(k + 1);
      end
      // A released selection falls back to the lowest pressed button.
      if (chosen != 0 && !stable_down[int'(chosen) - 1]) begin
         chosen = '0;
         for (int k = Buttons - 1; k >= 0; k--) begin
            if (stable_down[k]) chosen = ACTIVE_W'(k + 1);
         end
      end
      res.active_button     = chosen;
      res.led_bits          = (chosen != 0) ? LED_W'(1) << (int'(chosen) - 1) : '0;
      res.pressed_bits      = stable_down;
      res.selection_changed = (chosen != chosen_seen);
      stable_seen = stable_down;
      chosen_seen = chosen;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // Register writes, scan items and result items, all taken at the rising edge.
   always @(posedge clock) begin
      result_type want;
      result_type fresh;
      if (reset) begin
         settle_ms   = DEBOUNCE_TIME_RESET;
         settle_on   = DEBOUNCE_ENABLE_RESET;
         raw_seen    = '0;
         stable_down = '0;
         stable_seen = '0;
         for (int k = 0; k < Buttons; k++) edge_ms[k] = '0;
         chosen      = '0;
         chosen_seen = '0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE_TIME:   settle_ms = csr_wdata;
               CSR_DEBOUNCE_ENABLE: settle_on = csr_wdata[0];
               default: ;
            endcase
         end
         // Results are checked before this edge's scan is queued, so a scan's result never leaves with it.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               $display("%0t: result item with none expected, actual %0h/%0h/%0h/%0b",
                        $time, rsp_mon.active_button, rsp_mon.led_bits,
                        rsp_mon.pressed_bits, rsp_mon.selection_changed);
            end else begin
               want = due_results.pop_front();
               check_field("active_button", 32'(want.active_button),
                           32'(rsp_mon.active_button));
               check_field("led_bits", 32'(want.led_bits), 32'(rsp_mon.led_bits));
               check_field("pressed_bits", 32'(want.pressed_bits),
                           32'(rsp_mon.pressed_bits));
               check_field("selection_changed", 32'(want.selection_changed),
                           32'(rsp_mon.selection_changed));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_scan(req_mon.raw_levels, req_mon.now_ms, fresh);
            due_results.push_back(fresh);
         end
      end
      outstanding = due_results.size();
   end

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Top of the testbench for button_debounce_one_hot_select: drives scan items and
// register writes, stalls the result side, and gives the verdict.
// Depends on bdos_pkg, the channel interfaces and bdos_result_checker.
module tb;
   import bdos_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int SqueezeCycles = 300;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int mismatches;
   int outstanding;

   // Stimulus state of the sender and the receiver.
   bit sender_idles;
   bit receiver_idles;
   bit squeeze;
   logic [RAW_W-1:0]  levels;
   logic [TIME_W-1:0] now_ms;

   bdos_req_if req_chan ();
   bdos_rsp_if rsp_chan ();

   button_debounce_one_hot_select dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bdos_result_checker checker_unit (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offers one scan item, after an optional idle burst, and waits for its handshake.
   task automatic send_scan(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] stamp);
      int gap;
      gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.raw_levels <= raw;
      req_chan.now_ms     <= stamp;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stops offering and waits until every expected result item has arrived.
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Drives one register write for a single rising edge, starting at the next
   // falling edge so that back-to-back writes never collide.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // One block of random scans under one register setting. Most scans hold the
   // levels while time moves in steps small against the debounce time, so
   // presses and releases settle; single-button bounces and full-width noise
   // are mixed in, with occasional large time jumps.
   task automatic run_phase(input int count, input logic [DTIME_W-1:0] settle,
                            input logic enable);
      int span;
      logic [TIME_W-1:0] step;
      drain();
      write_reg(CSR_DEBOUNCE_TIME, settle);
      write_reg(CSR_DEBOUNCE_ENABLE, {15'($urandom()), enable});
      if ($urandom_range(0, 1) == 1)
         write_reg(CSR_INDEX_W'($urandom_range(2, 3)), CSR_DATA_W'($urandom()));
      span = int'(settle) / 4 + 1;
      now_ms = $urandom();
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0:             levels = RAW_W'($urandom());
            1, 2, 3, 4, 5: levels[$urandom_range(0, RAW_W - 1)] ^= 1'b1;
            default: ;
         endcase
         case ($urandom_range(0, 9))
            0:       step = '0;
            1:       step = $urandom();
            2:       step = TIME_W'(settle);
            default: step = TIME_W'($urandom_range(0, span));
         endcase
         now_ms += step;
         send_scan(levels, now_ms);
      end
   endtask

   // Result side: random stall bursts, one long hold-off on request.
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (squeeze) begin
            rsp_chan.ready <= 1'b0;
            repeat (SqueezeCycles - 1) @(negedge clock);
            squeeze = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Ends the run when no item moves on either channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("button_debounce_one_hot_select: mismatch");
            $finish;
         end
      end
   end

   // Main stimulus and verdict.
   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.raw_levels = '1;
      req_chan.now_ms     = '0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      sender_idles        = 1'b1;
      receiver_idles      = 1'b1;
      squeeze             = 1'b0;
      levels              = '1;
      now_ms              = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Reset settings: all buttons settle together and the highest one wins.
      send_scan(16'hFFFF, 32'd1000);
      send_scan(16'h0000, 32'd1100);
      send_scan(16'h0000, 32'd1119);
      send_scan(16'h0000, 32'd1120);
      // Releasing the selected button falls back to the lowest pressed one.
      send_scan(16'h7FFF, 32'd1130);
      send_scan(16'h7FFF, 32'd1150);
      // Everything released leaves no selection.
      send_scan(16'hFFFF, 32'd1160);
      send_scan(16'hFFFF, 32'd1180);
      // A bouncing press settles only after a full quiet debounce time.
      send_scan(16'hFFEF, 32'd1200);
      send_scan(16'hFFFF, 32'd1205);
      send_scan(16'hFFEF, 32'd1210);
      send_scan(16'hFFEF, 32'd1229);
      send_scan(16'hFFEF, 32'd1230);
      // A second press takes over; releasing it returns to the first button.
      send_scan(16'hFFED, 32'd1240);
      send_scan(16'hFFED, 32'd1260);
      send_scan(16'hFFEF, 32'd1270);
      send_scan(16'hFFEF, 32'd1290);
      // Elapsed time is taken across the wrap of the millisecond counter.
      send_scan(16'hFFEB, 32'hFFFF_FFF0);
      send_scan(16'hFFEB, 32'h0000_0004);
      send_scan(16'hFFFF, 32'h0000_0100);
      send_scan(16'hFFFF, 32'h0000_0200);

      // Zero debounce time: levels are taken at once.
      drain();
      write_reg(CSR_DEBOUNCE_TIME, 16'd0);
      send_scan(16'h5AA5, 32'd10);
      send_scan(16'hA55A, 32'd10);
      // Longest debounce time, just short of and exactly at the threshold.
      drain();
      write_reg(CSR_DEBOUNCE_TIME, 16'hFFFF);
      send_scan(16'h0F0F, 32'd100);
      send_scan(16'h0F0F, 32'd100 + 32'd65534);
      send_scan(16'h0F0F, 32'd100 + 32'd65535);
      // Debounce off passes levels straight through; unused indexes are ignored.
      drain();
      write_reg(CSR_DEBOUNCE_ENABLE, 16'hFFFE);
      write_reg(CSR_INDEX_W'(2), 16'hFFFF);
      write_reg(CSR_INDEX_W'(3), 16'hFFFF);
      // The result side holds off for a long stretch while scans keep coming,
      // so the output register fills and the input stalls.
      squeeze = 1'b1;
      send_scan(16'h1234, 32'd0);
      send_scan(16'hFFFF, 32'd0);

      // Random part.
      run_phase(250, DEBOUNCE_TIME_RESET, 1'b1);
      run_phase(200, 16'd0, 1'b1);
      run_phase(150, 16'hFFFF, 1'b1);
      run_phase(200, DTIME_W'($urandom_range(1, 200)), 1'b1);
      run_phase(200, DTIME_W'($urandom()), 1'b0);
      sender_idles = 1'b0;
      run_phase(200, 16'd3, 1'b1);
      receiver_idles = 1'b0;
      run_phase(200, DTIME_W'($urandom_range(0, 60)), 1'b1);

      drain();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("button_debounce_one_hot_select: match");
      else
         $display("button_debounce_one_hot_select: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/bdos_pkg.sv
hw/rtl/bdos_if.sv
hw/rtl/bdos_lane.sv
hw/rtl/bdos_select.sv
hw/rtl/button_debounce_one_hot_select.sv
dv/bdos_result_checker.sv
dv/tb.sv
